FILE: rtl/core/cbf_pkg.sv
// Shared types and constants for the circuit breaker block.
package cbf_pkg;

  // Fixed widths of the configuration registers
  localparam int THR_W      = 16;
  localparam int TIMEOUT_W  = 32;
  localparam int CFG_DATA_W = 32;
  localparam int CFG_IDX_W  = 2;

  // Register indexes on the configuration port
  localparam logic [CFG_IDX_W-1:0] CFG_FAILURE_THRESHOLD   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_HALF_OPEN_SUCCESSES = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_OPEN_TIMEOUT_TICKS  = 2'd2;

  // Register reset values
  localparam logic [THR_W-1:0]     FAILURE_THRESHOLD_RST   = 16'd5;
  localparam logic [THR_W-1:0]     HALF_OPEN_SUCCESSES_RST = 16'd3;
  localparam logic [TIMEOUT_W-1:0] OPEN_TIMEOUT_TICKS_RST  = 32'd30000;

  // Error classes of a failure report
  localparam logic [1:0] ECLASS_PLAIN = 2'd0;
  localparam logic [1:0] ECLASS_NONE  = 2'd1;
  localparam logic [1:0] ECLASS_DNS   = 2'd2;
  localparam logic [1:0] ECLASS_OTHER = 2'd3;

  typedef enum logic [1:0] {
    MODE_CLOSED = 2'd0,
    MODE_OPEN   = 2'd1,
    MODE_HALF   = 2'd2
  } mode_t;

  typedef enum logic [1:0] {
    ACT_REQUEST = 2'd0,
    ACT_SUCCESS = 2'd1,
    ACT_FAILURE = 2'd2,
    ACT_TICK    = 2'd3
  } action_t;

  typedef struct packed {
    logic [THR_W-1:0]     failure_threshold;
    logic [THR_W-1:0]     half_open_successes;
    logic [TIMEOUT_W-1:0] open_timeout_ticks;
  } cfg_t;

  typedef struct packed {
    logic  allowed;
    mode_t mode;
  } result_t;

endpackage

FILE: rtl/core/cbf_core.sv
// Breaker state machine: mode, counters, timer and per-item decision.
module cbf_core #(
  parameter int COUNT_BITS = 16,
  parameter int TIME_BITS  = 32
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              step,
  input  cbf_pkg::action_t  action,
  input  logic [1:0]        error_class,
  input  cbf_pkg::cfg_t     cfg,
  output cbf_pkg::result_t  result,
  output cbf_pkg::mode_t    mode
);
  import cbf_pkg::*;

  localparam int CNT_CMP_W  = (COUNT_BITS > THR_W) ? COUNT_BITS : THR_W;
  localparam int TIME_CMP_W = (TIME_BITS > TIMEOUT_W) ? TIME_BITS : TIMEOUT_W;

  mode_t                 mode_next;
  logic [COUNT_BITS-1:0] failures_seen, failures_seen_next;
  logic [COUNT_BITS-1:0] successes_seen, successes_seen_next;
  logic [TIME_BITS-1:0]  open_elapsed, open_elapsed_next;

  logic [COUNT_BITS-1:0] fail_inc;
  logic [COUNT_BITS-1:0] succ_inc;
  logic [TIME_BITS-1:0]  elapsed_inc;
  logic                  counted;
  logic                  fail_hit;
  logic                  succ_hit;
  logic                  timeout_hit;

  // Saturating increments and threshold compares
  assign fail_inc    = (&failures_seen) ? failures_seen : failures_seen + 1'b1;
  assign succ_inc    = (&successes_seen) ? successes_seen : successes_seen + 1'b1;
  assign elapsed_inc = (&open_elapsed) ? open_elapsed : open_elapsed + 1'b1;
  assign counted     = (error_class == ECLASS_PLAIN) || (error_class == ECLASS_OTHER);
  assign fail_hit    = CNT_CMP_W'(fail_inc) >= CNT_CMP_W'(cfg.failure_threshold);
  assign succ_hit    = CNT_CMP_W'(succ_inc) >= CNT_CMP_W'(cfg.half_open_successes);
  assign timeout_hit = TIME_CMP_W'(open_elapsed) >= TIME_CMP_W'(cfg.open_timeout_ticks);

  // Next state and counters
  always_comb begin
    mode_next           = mode;
    failures_seen_next  = failures_seen;
    successes_seen_next = successes_seen;
    open_elapsed_next   = open_elapsed;
    case (action)
      ACT_REQUEST: begin
        if (mode == MODE_OPEN && timeout_hit) begin
          mode_next           = MODE_HALF;
          successes_seen_next = '0;
        end
      end
      ACT_SUCCESS: begin
        if (mode == MODE_HALF) begin
          successes_seen_next = succ_inc;
          if (succ_hit) begin
            failures_seen_next = '0;
            mode_next          = MODE_CLOSED;
          end
        end else if (mode == MODE_CLOSED) begin
          failures_seen_next = '0;
        end
      end
      ACT_FAILURE: begin
        if (counted) begin
          if (mode == MODE_CLOSED) begin
            failures_seen_next = fail_inc;
            if (fail_hit) begin
              mode_next         = MODE_OPEN;
              open_elapsed_next = '0;
            end
          end else if (mode == MODE_HALF) begin
            mode_next         = MODE_OPEN;
            open_elapsed_next = '0;
          end
        end
      end
      ACT_TICK: begin
        open_elapsed_next = elapsed_inc;
      end
      default: begin
        mode_next = mode;
      end
    endcase
  end

  // Grant decision and reported mode
  always_comb begin
    result.allowed = (action == ACT_REQUEST) && ((mode != MODE_OPEN) || timeout_hit);
    result.mode    = mode_next;
  end

  // Advance state on each processed item
  always_ff @(posedge clk) begin
    if (rst) begin
      mode           <= MODE_CLOSED;
      failures_seen  <= '0;
      successes_seen <= '0;
      open_elapsed   <= '0;
    end else if (step) begin
      mode           <= mode_next;
      failures_seen  <= failures_seen_next;
      successes_seen <= successes_seen_next;
      open_elapsed   <= open_elapsed_next;
    end
  end

endmodule

FILE: rtl/core/circuit_breaker_fsm_top.sv
// Circuit breaker top level: config registers, input register, core, result register.
// An accepted item goes through the input register, then the result register;
// the core decides combinationally between the two.
// Throughput: one item per cycle while out_stall is low; the core updates its state on each processed item.
// A full result register that is stalled holds the input register, which then stalls input.
// Reset: synchronous, active high; mode closed, counters and timer zero,
// registers back to threshold 5, half-open successes 3, timeout 30000 ticks.
module circuit_breaker_fsm_top #(
  parameter int COUNT_BITS = 16,
  parameter int TIME_BITS  = 32
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_wr_en,
  input  logic [cbf_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [cbf_pkg::CFG_DATA_W-1:0]   cfg_data,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic [1:0]                       action,
  input  logic [1:0]                       error_class,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic                             allowed,
  output logic [1:0]                       breaker_state
);
  import cbf_pkg::*;

  cfg_t       cfg;
  logic       s1_valid;
  action_t    s1_action;
  logic [1:0] s1_eclass;
  logic       advance;
  logic       fire;
  result_t    core_result;
  mode_t      core_mode;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.failure_threshold   <= FAILURE_THRESHOLD_RST;
      cfg.half_open_successes <= HALF_OPEN_SUCCESSES_RST;
      cfg.open_timeout_ticks  <= OPEN_TIMEOUT_TICKS_RST;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        CFG_FAILURE_THRESHOLD:   cfg.failure_threshold   <= cfg_data[THR_W-1:0];
        CFG_HALF_OPEN_SUCCESSES: cfg.half_open_successes <= cfg_data[THR_W-1:0];
        CFG_OPEN_TIMEOUT_TICKS:  cfg.open_timeout_ticks  <= cfg_data[TIMEOUT_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Handshake: process the held item whenever the result register can take it
  assign advance  = !out_valid || !out_stall;
  assign fire     = s1_valid && advance;
  assign in_stall = s1_valid && !advance;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_valid && !in_stall) begin
      s1_valid <= 1'b1;
    end else if (fire) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s1_action <= action_t'(action);
      s1_eclass <= error_class;
    end
  end

  cbf_core #(
    .COUNT_BITS (COUNT_BITS),
    .TIME_BITS  (TIME_BITS)
  ) u_core (
    .clk         (clk),
    .rst         (rst),
    .step        (fire),
    .action      (s1_action),
    .error_class (s1_eclass),
    .cfg         (cfg),
    .result      (core_result),
    .mode        (core_mode)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (fire) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      allowed       <= core_result.allowed;
      breaker_state <= core_result.mode;
    end
  end

  // Only a request can be granted
  assert property (@(posedge clk) disable iff (rst)
    fire && s1_action != ACT_REQUEST |=> !allowed)
    else $error("grant reported for an item that is not a request");

  // Closed never moves straight to half open
  assert property (@(posedge clk) disable iff (rst)
    fire && core_mode == MODE_CLOSED |=> breaker_state != MODE_HALF)
    else $error("closed breaker went to half open");

  // Half open grants every request
  assert property (@(posedge clk) disable iff (rst)
    fire && s1_action == ACT_REQUEST && core_mode == MODE_HALF |=> allowed)
    else $error("request refused while half open");

  // Input stalls only behind a held item
  assert property (@(posedge clk) disable iff (rst)
    in_stall |-> s1_valid && out_valid && out_stall)
    else $error("input stalled without a blocked item");

endmodule
